>>> design/zpf_pkg.sv
// ----------------------------------------------------------------------------
// zpf_pkg
// Shared types and constants for the zero-phase first-order filter.
// ----------------------------------------------------------------------------
`default_nettype none

package zpf_pkg;

    // Sample and arithmetic widths
    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 8;
    localparam int COEFF_BITS  = 16;
    localparam int ACC_BITS    = SAMPLE_BITS + FRAC_BITS;

    // Block buffer
    localparam int MAX_SAMPLES = 64;
    localparam int ADDR_BITS   = $clog2(MAX_SAMPLES);
    localparam int CNT_BITS    = $clog2(MAX_SAMPLES + 1);

    // Configuration register map
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = COEFF_BITS;
    localparam logic [CFG_IDX_BITS-1:0] REG_FILTER_MODE     = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SMOOTHING_COEFF = 1'b1;
    localparam logic [COEFF_BITS-1:0]   COEFF_RESET         = 16'h8000;

    typedef logic [ADDR_BITS-1:0] t_addr;
    typedef logic [CNT_BITS-1:0]  t_cnt;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SEED_RD,
        ST_SEED_LD,
        ST_RD,
        ST_MUL,
        ST_UPD,
        ST_WR,
        ST_EM_RD,
        ST_EM_WAIT
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic  mem_we;
        logic  wr_result;   // 1: write pass result, 0: write input sample
        t_addr mem_addr;
        logic  rd_en;
        logic  seed_ld;
        logic  mul_en;
        logic  upd_en;
    } t_cmd;

endpackage

`default_nettype wire

>>> design/zpf_datapath.sv
// ----------------------------------------------------------------------------
// zpf_datapath
// Sample buffer, configuration registers and the smoother arithmetic:
// multiply, round, saturate, and the per-pass result.
// ----------------------------------------------------------------------------
`default_nettype none

module zpf_datapath (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire zpf_pkg::t_cmd                          i_cmd,
    input  wire logic signed [zpf_pkg::SAMPLE_BITS-1:0] i_sample_in,
    input  wire logic                                   i_cfg_we,
    input  wire logic [zpf_pkg::CFG_IDX_BITS-1:0]       i_cfg_idx,
    input  wire logic [zpf_pkg::CFG_DATA_BITS-1:0]      i_cfg_data,
    output logic signed [zpf_pkg::SAMPLE_BITS-1:0]      o_sample_out
);

    localparam int SB   = zpf_pkg::SAMPLE_BITS;
    localparam int FB   = zpf_pkg::FRAC_BITS;
    localparam int CB   = zpf_pkg::COEFF_BITS;
    localparam int AB   = zpf_pkg::ACC_BITS;
    localparam int DB   = AB + 1;            // difference width
    localparam int PB   = DB + CB + 1;       // product width
    localparam int STB  = PB - CB;           // step width
    localparam int SUMB = STB + 1;           // x + step width
    localparam int VB   = AB + 2;            // pass value width
    localparam int QB   = VB - FB;           // rounded pass value width

    // Configuration registers
    logic          r_mode;
    logic [CB-1:0] r_coeff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 1'b0;
            r_coeff <= zpf_pkg::COEFF_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                zpf_pkg::REG_FILTER_MODE:     r_mode  <= i_cfg_data[0];
                zpf_pkg::REG_SMOOTHING_COEFF: r_coeff <= i_cfg_data[CB-1:0];
                default: ;
            endcase
        end
    end

    // Sample buffer, registered read
    logic [SB-1:0] r_mem [zpf_pkg::MAX_SAMPLES];
    logic [SB-1:0] r_rd_data;
    logic [SB-1:0] w_wr_data;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_we) begin
            r_mem[i_cmd.mem_addr] <= w_wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_cmd.mem_addr];
        end
    end

    // Sample lifted to Q.8 and the difference to the smoother
    logic signed [AB-1:0] w_s_q8;
    logic signed [AB-1:0] r_x;
    logic signed [DB-1:0] w_diff;
    logic signed [PB-1:0] w_prod;
    logic signed [PB-1:0] r_prod;

    assign w_s_q8 = {r_rd_data, {FB{1'b0}}};
    assign w_diff = DB'(w_s_q8) - DB'(r_x);
    assign w_prod = $signed({1'b0, r_coeff}) * w_diff;

    // Round half up, add, saturate to the state width
    logic signed [PB-1:0]   w_prod_rnd;
    logic signed [STB-1:0]  w_step;
    logic signed [SUMB-1:0] w_sum;
    logic signed [AB-1:0]   w_x_sat;

    assign w_prod_rnd = r_prod + PB'(1 << (CB - 1));
    assign w_step     = w_prod_rnd[PB-1:CB];
    assign w_sum      = SUMB'(r_x) + SUMB'(w_step);

    always_comb begin
        if (!w_sum[SUMB-1] && (w_sum[SUMB-2:AB-1] != '0)) begin
            w_x_sat = {1'b0, {(AB-1){1'b1}}};
        end else if (w_sum[SUMB-1] && (w_sum[SUMB-2:AB-1] != '1)) begin
            w_x_sat = {1'b1, {(AB-1){1'b0}}};
        end else begin
            w_x_sat = w_sum[AB-1:0];
        end
    end

    // Smoother state: seed, multiply stage, update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= '0;
        end else if (i_cmd.seed_ld) begin
            r_x <= w_s_q8;
        end else if (i_cmd.upd_en) begin
            r_x <= w_x_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= w_prod;
        end
    end

    // Pass result: smoothed value or sample minus smoothed, rounded and saturated
    logic signed [VB-1:0] w_pass_v;
    logic signed [VB-1:0] w_pass_rnd;
    logic signed [QB-1:0] w_pass_q;
    logic signed [SB-1:0] w_pass_sat;

    assign w_pass_v   = r_mode ? (VB'(w_s_q8) - VB'(r_x)) : VB'(r_x);
    assign w_pass_rnd = w_pass_v + VB'(1 << (FB - 1));
    assign w_pass_q   = w_pass_rnd[VB-1:FB];

    always_comb begin
        if (!w_pass_q[QB-1] && (w_pass_q[QB-2:SB-1] != '0)) begin
            w_pass_sat = {1'b0, {(SB-1){1'b1}}};
        end else if (w_pass_q[QB-1] && (w_pass_q[QB-2:SB-1] != '1)) begin
            w_pass_sat = {1'b1, {(SB-1){1'b0}}};
        end else begin
            w_pass_sat = w_pass_q[SB-1:0];
        end
    end

    assign w_wr_data    = i_cmd.wr_result ? w_pass_sat : i_sample_in;
    assign o_sample_out = r_rd_data;

endmodule

`default_nettype wire

>>> design/zpf_ctrl.sv
// ----------------------------------------------------------------------------
// zpf_ctrl
// Sequencer: loads the block, steps the forward and backward passes over
// the buffer, and emits the filtered block in order.
// ----------------------------------------------------------------------------
`default_nettype none

module zpf_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire logic           i_is_last,
    input  wire logic           i_out_ready,
    output logic                o_in_ready,
    output logic                o_out_valid,
    output logic                o_end_of_block,
    output zpf_pkg::t_cmd       o_cmd
);

    zpf_pkg::t_state r_state, n_state;
    zpf_pkg::t_addr  r_idx, n_idx;
    zpf_pkg::t_cnt   r_cnt, n_cnt;
    logic            r_dir, n_dir;      // 0: forward pass, 1: backward pass

    logic            w_accept;
    logic            w_full;
    zpf_pkg::t_cnt   w_cnt_dec;
    zpf_pkg::t_addr  w_last;
    logic            w_pass_done;

    assign w_accept    = i_in_valid && (r_state == zpf_pkg::ST_LOAD);
    assign w_full      = (r_cnt == zpf_pkg::CNT_BITS'(zpf_pkg::MAX_SAMPLES));
    assign w_cnt_dec   = r_cnt - 1'b1;
    assign w_last      = w_cnt_dec[zpf_pkg::ADDR_BITS-1:0];
    assign w_pass_done = r_dir ? (r_idx == '0) : (r_idx == w_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= zpf_pkg::ST_LOAD;
            r_idx   <= '0;
            r_cnt   <= '0;
            r_dir   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_cnt   <= n_cnt;
            r_dir   <= n_dir;
        end
    end

    // Next state and counters
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_cnt   = r_cnt;
        n_dir   = r_dir;
        unique case (r_state)
            zpf_pkg::ST_LOAD: begin
                if (w_accept) begin
                    if (!w_full) begin
                        n_cnt = r_cnt + 1'b1;
                    end
                    // the last item is stored first, so a block is never empty
                    if (i_is_last) begin
                        n_dir   = 1'b0;
                        n_state = zpf_pkg::ST_SEED_RD;
                    end
                end
            end
            zpf_pkg::ST_SEED_RD: begin
                n_idx   = r_dir ? w_last : '0;
                n_state = zpf_pkg::ST_SEED_LD;
            end
            zpf_pkg::ST_SEED_LD: n_state = zpf_pkg::ST_RD;
            zpf_pkg::ST_RD:      n_state = zpf_pkg::ST_MUL;
            zpf_pkg::ST_MUL:     n_state = zpf_pkg::ST_UPD;
            zpf_pkg::ST_UPD:     n_state = zpf_pkg::ST_WR;
            zpf_pkg::ST_WR: begin
                if (w_pass_done) begin
                    if (!r_dir) begin
                        n_dir   = 1'b1;
                        n_state = zpf_pkg::ST_SEED_RD;
                    end else begin
                        n_idx   = '0;
                        n_state = zpf_pkg::ST_EM_RD;
                    end
                end else begin
                    n_idx   = r_dir ? (r_idx - 1'b1) : (r_idx + 1'b1);
                    n_state = zpf_pkg::ST_RD;
                end
            end
            zpf_pkg::ST_EM_RD: n_state = zpf_pkg::ST_EM_WAIT;
            zpf_pkg::ST_EM_WAIT: begin
                if (i_out_ready) begin
                    if (r_idx == w_last) begin
                        n_cnt   = '0;
                        n_state = zpf_pkg::ST_LOAD;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = zpf_pkg::ST_EM_RD;
                    end
                end
            end
            default: n_state = zpf_pkg::ST_LOAD;
        endcase
    end

    // Datapath commands and handshake outputs
    always_comb begin
        o_cmd          = '0;
        o_in_ready     = 1'b0;
        o_out_valid    = 1'b0;
        o_end_of_block = 1'b0;
        o_cmd.mem_addr = r_idx;
        unique case (r_state)
            zpf_pkg::ST_LOAD: begin
                o_in_ready     = 1'b1;
                o_cmd.mem_addr = r_cnt[zpf_pkg::ADDR_BITS-1:0];
                o_cmd.mem_we   = w_accept && !w_full;
            end
            zpf_pkg::ST_SEED_RD: begin
                o_cmd.mem_addr = r_dir ? w_last : '0;
                o_cmd.rd_en    = 1'b1;
            end
            zpf_pkg::ST_SEED_LD: o_cmd.seed_ld = 1'b1;
            zpf_pkg::ST_RD:      o_cmd.rd_en   = 1'b1;
            zpf_pkg::ST_MUL:     o_cmd.mul_en  = 1'b1;
            zpf_pkg::ST_UPD:     o_cmd.upd_en  = 1'b1;
            zpf_pkg::ST_WR: begin
                o_cmd.mem_we    = 1'b1;
                o_cmd.wr_result = 1'b1;
            end
            zpf_pkg::ST_EM_RD:   o_cmd.rd_en   = 1'b1;
            zpf_pkg::ST_EM_WAIT: begin
                o_out_valid    = 1'b1;
                o_end_of_block = (r_idx == w_last);
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

>>> design/zero_phase_first_order_filter.sv
// Sequence: after the last-marked item, each pass over the n held samples first seeds
// the smoother (seed read, seed load), then steps every sample through read, multiply,
// update and write-back on the single buffer port; results are then read and shown one
// by one, each held until the output side takes it. No item is taken while a block is
// filtered.
// Reset: synchronous active low; empties the block, mode low pass, coefficient 0x8000.
// ----------------------------------------------------------------------------
// zero_phase_first_order_filter
// Forward-backward first-order smoother over a buffered block of samples,
// low or high pass, results emitted in original order.
// ----------------------------------------------------------------------------
`default_nettype none

module zero_phase_first_order_filter (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_ready,
    input  wire logic signed [zpf_pkg::SAMPLE_BITS-1:0] i_sample_in,
    input  wire logic                                   i_is_last,
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_ready,
    output logic signed [zpf_pkg::SAMPLE_BITS-1:0]      o_sample_out,
    output logic                                        o_end_of_block,
    input  wire logic                                   i_cfg_we,
    input  wire logic [zpf_pkg::CFG_IDX_BITS-1:0]       i_cfg_idx,
    input  wire logic [zpf_pkg::CFG_DATA_BITS-1:0]      i_cfg_data
);

    zpf_pkg::t_cmd w_cmd;

    // Sequencer
    zpf_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_is_last      (i_is_last),
        .i_out_ready    (i_out_ready),
        .o_in_ready     (o_in_ready),
        .o_out_valid    (o_out_valid),
        .o_end_of_block (o_end_of_block),
        .o_cmd          (w_cmd)
    );

    // Buffer and arithmetic
    zpf_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_sample_in  (i_sample_in),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_sample_out (o_sample_out)
    );

endmodule

`default_nettype wire

>>> tb/sv/zpf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zpf_checker
// Monitors the sample, result and register ports of the zero-phase filter.
// Keeps its own copy of the held block and the registers, filters each block
// when its last item is taken, and checks every result item in order.
// ----------------------------------------------------------------------------
module zpf_checker (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    input  logic                                    i_in_ready,
    input  logic signed [zpf_pkg::SAMPLE_BITS-1:0]  i_sample_in,
    input  logic                                    i_is_last,
    input  logic                                    i_out_valid,
    input  logic                                    i_out_ready,
    input  logic signed [zpf_pkg::SAMPLE_BITS-1:0]  i_sample_out,
    input  logic                                    i_end_of_block,
    input  logic                                    i_cfg_we,
    input  logic [zpf_pkg::CFG_IDX_BITS-1:0]        i_cfg_idx,
    input  logic [zpf_pkg::CFG_DATA_BITS-1:0]       i_cfg_data,
    output int                                      o_fail_count,
    output int                                      o_results_pending,
    output int                                      o_results_checked,
    output int                                      o_blocks_done,
    output int                                      o_samples_dropped
);

    typedef struct packed {
        logic [zpf_pkg::SAMPLE_BITS-1:0] sample;
        logic                            block_end;
    } t_filtered_item;

    // Mirrored registers and block buffer
    logic                           mode_high = 1'b0;
    logic [zpf_pkg::COEFF_BITS-1:0] weight    = zpf_pkg::COEFF_RESET;
    longint                         block_buf [zpf_pkg::MAX_SAMPLES];
    int                             held_count = 0;
    t_filtered_item                 expected_results [$];

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("ERROR at %0t: %s: got %0d, expected %0d", $realtime, what, got, want);
        o_fail_count++;
    endtask

    function automatic longint clamp_signed(input longint v, input int bits);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    // x + w*(s - x), Q.8 state and Q0.16 weight, step rounded half up
    function automatic longint smooth_update(input longint x, input longint s_q8);
        longint prod;
        prod = longint'({48'd0, weight}) * (s_q8 - x);
        return clamp_signed(x + ((prod + (longint'(1) <<< (zpf_pkg::COEFF_BITS - 1)))
                                 >>> zpf_pkg::COEFF_BITS),
                            zpf_pkg::ACC_BITS);
    endfunction

    // Q.8 back to an integer sample, rounded half up and saturated
    function automatic longint to_sample(input longint v_q8);
        return clamp_signed((v_q8 + (longint'(1) <<< (zpf_pkg::FRAC_BITS - 1)))
                            >>> zpf_pkg::FRAC_BITS,
                            zpf_pkg::SAMPLE_BITS);
    endfunction

    function automatic longint pass_value(input longint s_q8, input longint x);
        if (mode_high)
            return to_sample(s_q8 - x);
        return to_sample(x);
    endfunction

    // Forward pass seeded with the first sample, backward pass seeded with
    // the last forward result, then queue the block in original order
    function automatic void filter_block(input int n);
        longint         x;
        longint         s;
        int             i;
        t_filtered_item item;
        if (n == 0)
            return;
        x = block_buf[0] <<< zpf_pkg::FRAC_BITS;
        for (i = 0; i < n; i++) begin
            s = block_buf[i] <<< zpf_pkg::FRAC_BITS;
            x = smooth_update(x, s);
            block_buf[i] = pass_value(s, x);
        end
        x = block_buf[n-1] <<< zpf_pkg::FRAC_BITS;
        for (i = n - 1; i >= 0; i--) begin
            s = block_buf[i] <<< zpf_pkg::FRAC_BITS;
            x = smooth_update(x, s);
            block_buf[i] = pass_value(s, x);
        end
        for (i = 0; i < n; i++) begin
            item.sample    = block_buf[i][zpf_pkg::SAMPLE_BITS-1:0];
            item.block_end = (i == n - 1);
            expected_results.push_back(item);
        end
    endfunction

    always @(posedge i_clk) begin : track
        t_filtered_item want;
        if (!i_rst_n) begin
            mode_high  = 1'b0;
            weight     = zpf_pkg::COEFF_RESET;
            held_count = 0;
            expected_results.delete();
        end else begin
            // register writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    zpf_pkg::REG_FILTER_MODE:     mode_high = i_cfg_data[0];
                    zpf_pkg::REG_SMOOTHING_COEFF: weight    = i_cfg_data;
                    default: ;
                endcase
            end

            // result items against the oldest expectation
            if (i_out_valid && i_out_ready) begin
                o_results_checked++;
                if (expected_results.size() == 0) begin
                    report_mismatch("result item with none expected", i_sample_out, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (i_sample_out !== $signed(want.sample))
                        report_mismatch("sample_out", i_sample_out, $signed(want.sample));
                    if (i_end_of_block !== want.block_end)
                        report_mismatch("end_of_block", longint'(i_end_of_block),
                                        longint'(want.block_end));
                end
            end

            // sample items; a full buffer drops the sample but honors the last mark
            if (i_in_valid && i_in_ready) begin
                if (held_count < zpf_pkg::MAX_SAMPLES) begin
                    block_buf[held_count] = i_sample_in;
                    held_count++;
                end else begin
                    o_samples_dropped++;
                end
                if (i_is_last) begin
                    filter_block(held_count);
                    held_count = 0;
                    o_blocks_done++;
                end
            end
        end
        o_results_pending = expected_results.size();
    end

endmodule

>>> tb/sv/tb_zero_phase_first_order_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_zero_phase_first_order_filter
// Drives sample blocks and register settings into the zero-phase filter with
// random idle gaps on both channels; zpf_checker predicts and checks results.
// ----------------------------------------------------------------------------
module tb_zero_phase_first_order_filter;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD      = 400;
    localparam int SETTLE_CYCLES  = 16;
    localparam int TAIL_CYCLES    = 700;
    localparam int RANDOM_ITEMS   = 450;
    localparam int RANDOM_PHASES  = 6;
    localparam int MAX_GAP        = 12;

    localparam logic MODE_LOW_PASS  = 1'b0;
    localparam logic MODE_HIGH_PASS = 1'b1;

    typedef enum int {
        WAVE_NOISE,
        WAVE_EXTREME,
        WAVE_DRIFT,
        WAVE_SQUARE
    } t_wave;

    logic                                   clk       = 1'b0;
    logic                                   rst_n     = 1'b0;
    logic                                   in_valid  = 1'b0;
    logic                                   in_ready;
    logic signed [zpf_pkg::SAMPLE_BITS-1:0] sample_in = '0;
    logic                                   is_last   = 1'b0;
    logic                                   out_valid;
    logic                                   out_ready = 1'b0;
    logic signed [zpf_pkg::SAMPLE_BITS-1:0] sample_out;
    logic                                   end_of_block;
    logic                                   cfg_we    = 1'b0;
    logic [zpf_pkg::CFG_IDX_BITS-1:0]       cfg_idx   = '0;
    logic [zpf_pkg::CFG_DATA_BITS-1:0]      cfg_data  = '0;
    logic                                   long_hold_req = 1'b0;

    int fail_count;
    int results_pending;
    int results_checked;
    int blocks_done;
    int samples_dropped;
    int samples_sent = 0;
    int quiet_cycles = 0;

    zero_phase_first_order_filter u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_sample_in    (sample_in),
        .i_is_last      (is_last),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_sample_out   (sample_out),
        .o_end_of_block (end_of_block),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data)
    );

    zpf_checker u_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_ready        (in_ready),
        .i_sample_in       (sample_in),
        .i_is_last         (is_last),
        .i_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .i_sample_out      (sample_out),
        .i_end_of_block    (end_of_block),
        .i_cfg_we          (cfg_we),
        .i_cfg_idx         (cfg_idx),
        .i_cfg_data        (cfg_data),
        .o_fail_count      (fail_count),
        .o_results_pending (results_pending),
        .o_results_checked (results_checked),
        .o_blocks_done     (blocks_done),
        .o_samples_dropped (samples_dropped)
    );

    // 2 ns clock
    initial begin
        forever #1 clk = ~clk;
    end

    // Watchdog: too long without any item or register write
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("Watchdog expired after %0d idle cycles", WATCHDOG_LIMIT);
                $display("Test completed with failures");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Offer one sample item after an idle gap; returns on the falling edge after acceptance
    task automatic send_item(input logic signed [zpf_pkg::SAMPLE_BITS-1:0] value,
                             input logic last, input int gap);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        sample_in <= value;
        is_last   <= last;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        samples_sent++;
    endtask

    task automatic write_reg(input logic [zpf_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [zpf_pkg::CFG_DATA_BITS-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Hold the sender until every expected result has come, then let the block settle
    task automatic drain_results(input int settle);
        in_valid <= 1'b0;
        while (results_pending != 0) @(negedge clk);
        repeat (settle) @(negedge clk);
    endtask

    function automatic logic signed [zpf_pkg::SAMPLE_BITS-1:0] draw_sample(input t_wave wave,
                                                                            input int level);
        int v;
        case (wave)
            WAVE_NOISE: v = int'($urandom_range(0, 65535)) - 32768;
            WAVE_EXTREME: begin
                case ($urandom_range(0, 3))
                    0:       v = -32768;
                    1:       v = 32767;
                    2:       v = 0;
                    default: v = -1;
                endcase
            end
            WAVE_DRIFT:  v = level + int'($urandom_range(0, 1023)) - 512;
            default:     v = ($urandom_range(0, 1) != 0) ? level : -level;
        endcase
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[zpf_pkg::SAMPLE_BITS-1:0];
    endfunction

    // Mostly short blocks, some long, now and then more than the buffer holds
    function automatic int draw_block_len();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12)
            return $urandom_range(1, 8);
        if (r < 17)
            return $urandom_range(9, 40);
        if (r < 19)
            return $urandom_range(41, zpf_pkg::MAX_SAMPLES);
        return $urandom_range(zpf_pkg::MAX_SAMPLES + 1, zpf_pkg::MAX_SAMPLES + 6);
    endfunction

    task automatic send_random_block(input int len, input bit burst);
        t_wave wave;
        int    level;
        int    k;
        bit    no_gaps;
        wave    = t_wave'($urandom_range(0, 3));
        level   = int'($urandom_range(0, 65535)) - 32768;
        no_gaps = burst || ($urandom_range(0, 3) == 0);
        for (k = 0; k < len; k++)
            send_item(draw_sample(wave, level), k == len - 1,
                      no_gaps ? 0 : $urandom_range(0, MAX_GAP));
    endtask

    // Result side: random stall per item, steady stretches, one long hold-off
    initial begin : result_sink
        bit hold_done;
        bit steady;
        int stall;
        hold_done = 1'b0;
        steady    = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            if ($urandom_range(0, 15) == 0)
                steady = !steady;
            if (long_hold_req && !hold_done) begin
                stall     = LONG_HOLD;
                hold_done = 1'b1;
            end else if (steady) begin
                stall = 0;
            end else begin
                stall = $urandom_range(0, MAX_GAP);
            end
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    initial begin : stimulus
        int phase_idx;
        int len;
        int random_start;
        logic mode_sel;
        logic [zpf_pkg::COEFF_BITS-1:0] weight_sel;

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: low pass, half weight; single sample, full-scale swings
        send_item(32767, 1'b1, 0);
        send_item(-32768, 1'b0, 0);
        send_item(32767, 1'b0, 1);
        send_item(-32768, 1'b0, 0);
        send_item(32767, 1'b1, 2);
        drain_results(SETTLE_CYCLES);

        // High pass at full weight on full-scale swings; single sample gives zero
        write_reg(zpf_pkg::REG_FILTER_MODE, MODE_HIGH_PASS);
        write_reg(zpf_pkg::REG_SMOOTHING_COEFF, 16'hffff);
        send_item(-32768, 1'b0, 0);
        send_item(32767, 1'b0, 0);
        send_item(-32768, 1'b0, 3);
        send_item(32767, 1'b1, 0);
        send_item(12345, 1'b1, 0);
        drain_results(SETTLE_CYCLES);

        // Zero weight holds the seed through both passes
        write_reg(zpf_pkg::REG_FILTER_MODE, MODE_LOW_PASS);
        write_reg(zpf_pkg::REG_SMOOTHING_COEFF, 16'h0000);
        send_item(-5, 1'b0, 0);
        send_item(100, 1'b0, 3);
        send_item(32767, 1'b1, 0);
        drain_results(SETTLE_CYCLES);

        // Smallest nonzero weight, high pass
        write_reg(zpf_pkg::REG_FILTER_MODE, MODE_HIGH_PASS);
        write_reg(zpf_pkg::REG_SMOOTHING_COEFF, 16'h0001);
        send_item(0, 1'b0, 0);
        send_item(-1, 1'b0, 0);
        send_item(1, 1'b0, 1);
        send_item(-32768, 1'b0, 0);
        send_item(32767, 1'b0, 0);
        send_item(7, 1'b1, 0);

        // Random blocks, one register setting per phase
        random_start = samples_sent;
        for (phase_idx = 0; phase_idx < RANDOM_PHASES; phase_idx++) begin
            drain_results(SETTLE_CYCLES);
            case (phase_idx)
                0: begin
                    mode_sel   = MODE_LOW_PASS;
                    weight_sel = zpf_pkg::COEFF_BITS'($urandom_range(1, 65535));
                end
                1: begin
                    mode_sel   = MODE_HIGH_PASS;
                    weight_sel = 16'hffff;
                end
                2: begin
                    mode_sel   = MODE_LOW_PASS;
                    weight_sel = 16'h0001;
                end
                3: begin
                    mode_sel   = MODE_HIGH_PASS;
                    weight_sel = zpf_pkg::COEFF_BITS'($urandom_range(1, 65535));
                end
                4: begin
                    mode_sel   = MODE_LOW_PASS;
                    weight_sel = 16'h0000;
                end
                default: begin
                    mode_sel   = MODE_HIGH_PASS;
                    weight_sel = zpf_pkg::COEFF_BITS'($urandom_range(256, 8192));
                end
            endcase
            write_reg(zpf_pkg::REG_FILTER_MODE, mode_sel);
            write_reg(zpf_pkg::REG_SMOOTHING_COEFF, weight_sel);

            // Sender keeps offering while the result side holds off
            if (phase_idx == 3)
                long_hold_req <= 1'b1;

            // Buffer boundaries: exactly full, overflow, dropped last-marked sample
            case (phase_idx)
                1:       len = zpf_pkg::MAX_SAMPLES;
                2:       len = zpf_pkg::MAX_SAMPLES + 2;
                4:       len = zpf_pkg::MAX_SAMPLES + 1;
                default: len = draw_block_len();
            endcase
            send_random_block(len, phase_idx == 3);

            while (samples_sent < random_start + (phase_idx + 1) * RANDOM_ITEMS / RANDOM_PHASES)
                send_random_block(draw_block_len(), phase_idx == 3);
        end

        drain_results(TAIL_CYCLES);
        $display("Run covered %0d samples in %0d blocks (%0d dropped on a full buffer), %0d results",
                 samples_sent, blocks_done, samples_dropped, results_checked);
        $display("in both modes with weights 0, 1, 65535 and random, plus a long result stall.");
        if (fail_count == 0 && results_pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
